/* hdl/aifp_pkg.sv */
// Shared types, constants and helpers for the axis input feasibility projector.
// Used by aifp_div and axis_input_feasibility_projector; depends on nothing.
package aifp_pkg;

   localparam int DATA_W      = 32;
   localparam int FRAC_BITS   = 16;
   localparam int DT_W        = 20;
   localparam int HOR_W       = 7;
   localparam int MAX_HORIZON = 64;
   localparam int NUM_W       = 61;   // widest exact numerator, signed
   localparam int DEN_W       = 52;   // widest exact denominator, unsigned
   localparam int QUO_BITS    = 33;   // quotient bits before saturation
   localparam int CSR_IDX_W   = 4;
   localparam int IN_W        = 104;
   localparam int OUT_W       = 160;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_VEL_MIN   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_VEL_MAX   = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ACC_MIN   = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ACC_MAX   = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_IN_MIN    = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_IN_MAX    = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_STEP      = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_ORDER     = 4'd7;

   localparam logic [DT_W-1:0] STEP_RESET = 20'd6554;

   // request to the shared divider
   typedef struct packed {
      logic                    start;
      logic                    up;     // round toward +inf when set
      logic signed [NUM_W-1:0] num;
      logic [DEN_W-1:0]        den;
   } div_req_type;

   // saturate a signed 64-bit value into 32 bits
   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] x);
      logic signed [63:0] hi_lim;
      logic signed [63:0] lo_lim;
      hi_lim = 64'sh0000_0000_7FFF_FFFF;
      lo_lim = -64'sh0000_0000_8000_0000;
      if (x > hi_lim) begin
         return 32'sh7FFF_FFFF;
      end else if (x < lo_lim) begin
         return 32'sh8000_0000;
      end
      return x[DATA_W-1:0];
   endfunction

endpackage

/* hdl/aifp_div.sv */
// Bit-serial restoring divider: num * 2^16 / den, directed rounding, 32-bit saturation.
// Depends on aifp_pkg.
module aifp_div (
   input  logic                             clock,
   input  logic                             reset,
   input  aifp_pkg::div_req_type            div_req,
   output logic                             div_done,
   output logic signed [aifp_pkg::DATA_W-1:0] div_quo
);

   typedef enum logic [2:0] {
      D_IDLE = 3'b001,
      D_RUN  = 3'b010,
      D_FIN  = 3'b100
   } dstate_type;

   dstate_type dstate_ff, dstate_in;

   logic [aifp_pkg::NUM_W-2:0]    mag;
   logic                          neg_ff;
   logic                          up_ff;
   logic [aifp_pkg::DEN_W-1:0]    den_ff;
   logic [aifp_pkg::DEN_W-1:0]    rem_ff;
   logic [aifp_pkg::QUO_BITS-1:0] sh_ff;
   logic [aifp_pkg::QUO_BITS:0]   quo_ff;
   logic [5:0]                    cnt_ff;
   logic                          done_ff;
   logic signed [aifp_pkg::DATA_W-1:0] res_ff;
   logic [aifp_pkg::DEN_W:0]      trial;
   logic                          fits;
   logic [aifp_pkg::QUO_BITS:0]   qfin;
   logic signed [63:0]            qsig;
   logic [69:0]                   ovf_lim;

   // magnitude of the numerator
   always_comb begin
      if (div_req.num[aifp_pkg::NUM_W-1]) begin
         mag = (aifp_pkg::NUM_W-1)'(-div_req.num);
      end else begin
         mag = div_req.num[aifp_pkg::NUM_W-2:0];
      end
      ovf_lim = {1'b0, div_req.den, 17'b0};
   end

   // one quotient bit per cycle
   assign trial = {rem_ff, sh_ff[aifp_pkg::QUO_BITS-1]};
   assign fits  = trial >= {1'b0, den_ff};

   // directed rounding on a nonzero remainder
   always_comb begin
      qfin = quo_ff + {{aifp_pkg::QUO_BITS{1'b0}}, ((rem_ff != '0) && (neg_ff != up_ff))};
      qsig = neg_ff ? -$signed({30'b0, qfin}) : $signed({30'b0, qfin});
   end

   always_comb begin
      dstate_in = dstate_ff;
      case (dstate_ff)
         D_IDLE:  if (div_req.start) dstate_in = D_RUN;
         D_RUN:   if (cnt_ff == '0) dstate_in = D_FIN;
         D_FIN:   dstate_in = D_IDLE;
         default: dstate_in = D_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dstate_ff <= D_IDLE;
         done_ff   <= 1'b0;
      end else begin
         dstate_ff <= dstate_in;
         done_ff   <= (dstate_ff == D_FIN);
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (dstate_ff)
         D_IDLE: begin
            neg_ff <= div_req.num[aifp_pkg::NUM_W-1];
            up_ff  <= div_req.up;
            den_ff <= div_req.den;
            if ({10'b0, mag} >= ovf_lim) begin
               // quotient at least 2^33: saturates whatever the low bits
               rem_ff <= '0;
               sh_ff  <= '0;
               quo_ff <= {1'b1, {aifp_pkg::QUO_BITS{1'b0}}};
               cnt_ff <= '0;
            end else begin
               rem_ff <= aifp_pkg::DEN_W'(mag >> 17);
               sh_ff  <= {mag[16:0], 16'b0};
               quo_ff <= '0;
               cnt_ff <= 6'(aifp_pkg::QUO_BITS);
            end
         end
         D_RUN: begin
            if (cnt_ff != '0) begin
               rem_ff <= fits ? aifp_pkg::DEN_W'(trial - {1'b0, den_ff})
                              : trial[aifp_pkg::DEN_W-1:0];
               sh_ff  <= {sh_ff[aifp_pkg::QUO_BITS-2:0], 1'b0};
               quo_ff <= {quo_ff[aifp_pkg::QUO_BITS-1:0], fits};
               cnt_ff <= cnt_ff - 6'd1;
            end
         end
         D_FIN: res_ff <= aifp_pkg::sat32(qsig);
         default: ;
      endcase
   end

   assign div_done = done_ff;
   assign div_quo  = res_ff;

endmodule

/* hdl/axis_input_feasibility_projector.sv */
// Top level: register file, sequencer over horizon steps, shared multiplier and divider.
// Depends on aifp_pkg and aifp_div.
//
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | tdata: velocity, acceleration, reference, horizon
//  rsp     | out | rsp_tvalid/tready    | tdata: input, velocity, accel, low, high; tuser: feasible
//  csr     | in  | csr_valid/csr_ready  | csr_index, csr_wdata
//
// Each item runs N horizon steps (1, or the clamped horizon in held modes) with D divisions
// per step (2 acceleration, 4 jerk), each on the bit-serial divider. A saturating division
// is shorter, and an empty interval skips the S_MUL_U and S_MUL_NV states. Held jerk with
// horizon 64 is the longest item; invalid items go from S_IDLE straight to S_DONE.
// Reset is synchronous; it clears control state and loads the register defaults.
// A finished result waits in the output register while the next item is accepted.
module axis_input_feasibility_projector (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [31:0] cur_velocity, [63:32] cur_acceleration, [95:64] reference_input,
   // [102:96] horizon_steps, [103] zero
   input  logic [aifp_pkg::IN_W-1:0]         req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [31:0] applied_input, [63:32] next_velocity, [95:64] next_acceleration,
   // [127:96] bound_low, [159:128] bound_high
   output logic [aifp_pkg::OUT_W-1:0]        rsp_tdata,
   // [0] is_feasible
   output logic                              rsp_tuser,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [aifp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [aifp_pkg::DATA_W-1:0]       csr_wdata
);

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_MUL_AD = 9'b000000010,
      S_MUL_DD = 9'b000000100,
      S_DIV_GO = 9'b000001000,
      S_DIV_WT = 9'b000010000,
      S_CLAMP  = 9'b000100000,
      S_MUL_U  = 9'b001000000,
      S_MUL_NV = 9'b010000000,
      S_DONE   = 9'b100000000
   } state_type;

   state_type state_ff;

   // configuration registers
   logic signed [31:0] vmin_ff, vmax_ff, amin_ff, amax_ff, imin_ff, imax_ff;
   logic [aifp_pkg::DT_W-1:0] dt_ff;
   logic [1:0] order_ff;

   // item registers
   logic signed [31:0] v_ff, a_ff, r_ff;
   logic [aifp_pkg::HOR_W-1:0] n_ff, count_ff;
   logic [1:0] k_ff;
   logic jerk_ff;
   logic signed [31:0] lo_ff, hi_ff, u_ff, na_ff, nv_ff;
   logic feas_ff;
   logic signed [51:0] ad_ff;
   logic signed [58:0] resp_ff;
   logic [39:0] dd_ff;
   logic [45:0] dn_ff;
   logic [aifp_pkg::DEN_W-1:0] den1_ff, den2_ff;

   // output register
   logic rsp_valid_ff;
   logic [aifp_pkg::OUT_W-1:0] rsp_data_ff;
   logic rsp_user_ff;

   // shared multiplier
   logic signed [32:0] mul_a;
   logic signed [20:0] mul_b;
   logic signed [53:0] prod;

   // divider interface
   aifp_pkg::div_req_type div_req;
   logic div_done;
   logic signed [31:0] div_quo;

   logic req_acc;
   logic signed [31:0] in_v, in_a, in_r;
   logic [aifp_pkg::HOR_W-1:0] in_h;
   logic bad;
   logic [1:0] last_k;
   logic signed [32:0] d_lo, d_hi, d_sel;
   logic signed [60:0] vnum;
   logic signed [38:0] na_sum, nv_sum;

   assign in_v = req_tdata[31:0];
   assign in_a = req_tdata[63:32];
   assign in_r = req_tdata[95:64];
   assign in_h = req_tdata[102:96];

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign bad = (vmin_ff > vmax_ff) || (amin_ff > amax_ff) || (imin_ff > imax_ff) ||
                (dt_ff == '0) || (order_ff[1] && (in_h == '0));

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         vmin_ff  <= '0;
         vmax_ff  <= '0;
         amin_ff  <= '0;
         amax_ff  <= '0;
         imin_ff  <= '0;
         imax_ff  <= '0;
         dt_ff    <= aifp_pkg::STEP_RESET;
         order_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            aifp_pkg::REG_VEL_MIN: vmin_ff  <= csr_wdata;
            aifp_pkg::REG_VEL_MAX: vmax_ff  <= csr_wdata;
            aifp_pkg::REG_ACC_MIN: amin_ff  <= csr_wdata;
            aifp_pkg::REG_ACC_MAX: amax_ff  <= csr_wdata;
            aifp_pkg::REG_IN_MIN:  imin_ff  <= csr_wdata;
            aifp_pkg::REG_IN_MAX:  imax_ff  <= csr_wdata;
            aifp_pkg::REG_STEP:    dt_ff    <= csr_wdata[aifp_pkg::DT_W-1:0];
            aifp_pkg::REG_ORDER:   order_ff <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // multiplier operand selection
   always_comb begin
      mul_b = $signed({1'b0, dt_ff});
      case (state_ff)
         S_MUL_AD: mul_a = {a_ff[31], a_ff};
         S_MUL_DD: mul_a = $signed({13'b0, dt_ff});
         S_MUL_U:  mul_a = {u_ff[31], u_ff};
         S_MUL_NV: mul_a = {na_ff[31], na_ff};
         default:  mul_a = '0;
      endcase
      prod = mul_a * mul_b;
   end

   // numerator / denominator for the current quotient
   assign last_k = jerk_ff ? 2'd3 : 2'd1;
   always_comb begin
      if (jerk_ff && !k_ff[1]) begin
         d_lo = $signed({amin_ff[31], amin_ff}) - $signed({a_ff[31], a_ff});
         d_hi = $signed({amax_ff[31], amax_ff}) - $signed({a_ff[31], a_ff});
      end else begin
         d_lo = $signed({vmin_ff[31], vmin_ff}) - $signed({v_ff[31], v_ff});
         d_hi = $signed({vmax_ff[31], vmax_ff}) - $signed({v_ff[31], v_ff});
      end
      d_sel = k_ff[0] ? d_hi : d_lo;
      // velocity term for jerk: (limit - v) * 2^16 - n*a*dt
      vnum = ($signed({{28{d_sel[32]}}, d_sel}) <<< aifp_pkg::FRAC_BITS)
             - $signed({{2{resp_ff[58]}}, resp_ff});
      div_req.start = (state_ff == S_DIV_GO);
      div_req.up    = !k_ff[0];
      if (k_ff[1]) begin
         div_req.num = vnum;
         div_req.den = den2_ff;
      end else begin
         div_req.num = {{28{d_sel[32]}}, d_sel};
         div_req.den = den1_ff;
      end
   end

   aifp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_done (div_done),
      .div_quo  (div_quo)
   );

   assign na_sum = $signed({{7{a_ff[31]}}, a_ff}) + 39'(prod >>> aifp_pkg::FRAC_BITS);
   assign nv_sum = $signed({{7{v_ff[31]}}, v_ff}) + 39'(prod >>> aifp_pkg::FRAC_BITS);

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_acc) state_ff <= bad ? S_DONE : S_MUL_AD;
            end
            S_MUL_AD: state_ff <= S_MUL_DD;
            S_MUL_DD: state_ff <= S_DIV_GO;
            S_DIV_GO: state_ff <= S_DIV_WT;
            S_DIV_WT: begin
               if (div_done) begin
                  if ((k_ff == last_k) && (n_ff == count_ff)) state_ff <= S_CLAMP;
                  else state_ff <= S_DIV_GO;
               end
            end
            S_CLAMP:  state_ff <= (lo_ff > hi_ff) ? S_DONE : S_MUL_U;
            S_MUL_U:  state_ff <= S_MUL_NV;
            S_MUL_NV: state_ff <= S_DONE;
            S_DONE: begin
               if (!rsp_valid_ff || rsp_tready) state_ff <= S_IDLE;
            end
            default:  state_ff <= S_IDLE;
         endcase
      end
   end

   // item datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            v_ff    <= in_v;
            a_ff    <= in_a;
            r_ff    <= in_r;
            jerk_ff <= order_ff[0];
            feas_ff <= 1'b0;
            n_ff    <= 7'd1;
            k_ff    <= '0;
            den1_ff <= aifp_pkg::DEN_W'(dt_ff);
            if (order_ff[1]) begin
               count_ff <= (in_h > 7'(aifp_pkg::MAX_HORIZON)) ?
                           7'(aifp_pkg::MAX_HORIZON) : in_h;
            end else begin
               count_ff <= 7'd1;
            end
            if (order_ff[0]) begin
               lo_ff <= imin_ff;
               hi_ff <= imax_ff;
            end else begin
               lo_ff <= (imin_ff > amin_ff) ? imin_ff : amin_ff;
               hi_ff <= (imax_ff < amax_ff) ? imax_ff : amax_ff;
            end
         end
         S_MUL_AD: begin
            ad_ff   <= prod[51:0];
            resp_ff <= 59'($signed(prod[51:0]));
         end
         S_MUL_DD: begin
            dd_ff   <= prod[39:0];
            dn_ff   <= 46'(prod[39:0]);
            den2_ff <= aifp_pkg::DEN_W'(prod[39:0]);
         end
         S_DIV_WT: begin
            if (div_done) begin
               if (!k_ff[0]) begin
                  if (div_quo > lo_ff) lo_ff <= div_quo;
               end else begin
                  if (div_quo < hi_ff) hi_ff <= div_quo;
               end
               if (k_ff == last_k) begin
                  // advance to the next horizon step
                  k_ff    <= '0;
                  n_ff    <= n_ff + 7'd1;
                  den1_ff <= den1_ff + aifp_pkg::DEN_W'(dt_ff);
                  dn_ff   <= dn_ff + 46'(dd_ff);
                  den2_ff <= den2_ff + aifp_pkg::DEN_W'(dn_ff + 46'(dd_ff));
                  resp_ff <= resp_ff + 59'(ad_ff);
               end else begin
                  k_ff <= k_ff + 2'd1;
               end
            end
         end
         S_CLAMP: begin
            u_ff    <= (r_ff < lo_ff) ? lo_ff : ((r_ff > hi_ff) ? hi_ff : r_ff);
            feas_ff <= !(lo_ff > hi_ff);
         end
         S_MUL_U: begin
            na_ff <= jerk_ff ? aifp_pkg::sat32(64'(na_sum)) : u_ff;
         end
         S_MUL_NV: nv_ff <= aifp_pkg::sat32(64'(nv_sum));
         default: ;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready)) begin
         rsp_user_ff <= feas_ff;
         rsp_data_ff <= feas_ff ? {hi_ff, lo_ff, na_ff, nv_ff, u_ff} : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // checks
   a_infeas_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("infeasible item with nonzero payload");

   a_feas_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         ($signed(rsp_tdata[127:96]) <= $signed(rsp_tdata[159:128])) &&
         ($signed(rsp_tdata[31:0]) >= $signed(rsp_tdata[127:96])) &&
         ($signed(rsp_tdata[31:0]) <= $signed(rsp_tdata[159:128])))
      else $error("applied input outside its interval");

   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV_WT)
      else $error("divider result outside wait state");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_tready)
      else $error("ready right after accept");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV_WT |-> (n_ff >= 7'd1) && (n_ff <= count_ff))
      else $error("horizon step out of range");

endmodule
